@@ src/ppe_pkg.sv @@
// Package: widths, sequencer states and field layout for the prime power exponent core.
package ppe_pkg;

	localparam int ValW   = 31;
	localparam int PrimeW = 14;
	localparam int ExpW   = 5;
	localparam int TrialW = 8;
	localparam int StepW  = 5;
	localparam int InDataW  = 48;
	localparam int OutDataW = 8;

	localparam logic [StepW-1:0] LastStep = StepW'(ValW - 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_PRIME = 4'b0010,
		ST_VAL   = 4'b0100,
		ST_FIN   = 4'b1000
	} state_t;

endpackage

@@ src/prime_power_exponent_core.sv @@
// Top level: trial-division primality test and p-adic valuation over one shared radix-2 divider.
//
//  channel  dir  beat fields (lsb first)
//  s_*      in   tdata: value[30:0], prime[44:31], zero pad [47:45]
//  m_*      out  tuser: valid_res; tdata: exponent[4:0], zero pad [7:5]
//
// One restoring divider does every division, one quotient bit per cycle; the remainder
// is then handed to the sequencer. An item runs t trial divisions, t = trial divisors
// used (at most 126), then e + 1 valuation divisions, e = exponent found; a composite
// stops at its factor; rejected candidates or a zero value do not use the divider.
// s_tready is high only when idle; the result register lets a new beat in while the
// last result waits on m_tready. Reset clears control state only; no clearing pass.
module prime_power_exponent_core
	import ppe_pkg::*;
#(
	parameter int PRIME_LIMIT = 16384
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [InDataW-1:0]  s_tdata,   // value[30:0], prime[44:31]
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [OutDataW-1:0] m_tdata,   // exponent[4:0]
	output logic                m_tuser    // valid_res
);

	localparam logic [16:0] LimitW = 17'(PRIME_LIMIT);

	state_t              state_q;
	logic [ValW-1:0]     v_q;
	logic [PrimeW-1:0]   p_q;
	logic [TrialW-1:0]   d_q;
	logic [ExpW-1:0]     cnt_q;
	logic                res_valid_q;
	logic [ExpW-1:0]     res_exp_q;
	logic                out_valid_q;
	logic                out_flag_q;
	logic [ExpW-1:0]     out_exp_q;

	logic [ValW-1:0]     div_quo_q;
	logic [PrimeW-1:0]   div_rem_q;
	logic [PrimeW-1:0]   div_den_q;
	logic [StepW-1:0]    div_step_q;
	logic                div_busy_q;
	logic                div_done_q;

	logic                in_fire;
	logic [ValW-1:0]     in_v;
	logic [PrimeW-1:0]   in_p;
	logic                in_bad;
	logic                in_small;
	logic [TrialW-1:0]   d_nxt;
	logic [15:0]         d_sq;
	logic                d_past;
	logic                rem_zero;
	logic                div_start;
	logic [ValW-1:0]     div_num;
	logic [PrimeW-1:0]   div_den;
	logic [PrimeW:0]     div_shift;
	logic                div_ge;
	logic                out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign in_fire  = s_tvalid & s_tready;
	assign in_v     = s_tdata[ValW-1:0];
	assign in_p     = s_tdata[ValW+PrimeW-1:ValW];
	assign in_bad   = (in_v == '0) || (in_p < PrimeW'(2)) || ({3'b000, in_p} >= LimitW);
	assign in_small = (in_p < PrimeW'(4));
	assign d_nxt    = d_q + TrialW'(1);
	assign d_sq     = 16'(d_nxt) * 16'(d_nxt);
	assign d_past   = d_sq > {2'b00, p_q};
	assign rem_zero = (div_rem_q == '0);
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_fire && !in_bad) begin
					div_start = 1'b1;
					if (in_small) begin
						div_num = in_v;
						div_den = in_p;
					end else begin
						div_num = ValW'(in_p);
						div_den = PrimeW'(2);
					end
				end
			end
			ST_PRIME: begin
				if (div_done_q && !rem_zero) begin
					div_start = 1'b1;
					if (d_past) begin
						div_num = v_q;
						div_den = p_q;
					end else begin
						div_num = ValW'(p_q);
						div_den = PrimeW'(d_nxt);
					end
				end
			end
			ST_VAL: begin
				if (div_done_q && rem_zero) begin
					div_start = 1'b1;
					div_num   = div_quo_q;
					div_den   = p_q;
				end
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	// shared restoring divider
	assign div_shift = {div_rem_q, div_quo_q[ValW-1]};
	assign div_ge    = div_shift >= {1'b0, div_den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
			div_step_q <= '0;
		end else if (div_start) begin
			div_busy_q <= 1'b1;
			div_done_q <= 1'b0;
			div_step_q <= '0;
		end else if (div_busy_q) begin
			div_step_q <= div_step_q + StepW'(1);
			if (div_step_q == LastStep) begin
				div_busy_q <= 1'b0;
				div_done_q <= 1'b1;
			end
		end else begin
			div_done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_start) begin
			div_quo_q <= div_num;
			div_rem_q <= '0;
			div_den_q <= div_den;
		end else if (div_busy_q) begin
			if (div_ge) begin
				div_rem_q <= PrimeW'(div_shift - {1'b0, div_den_q});
				div_quo_q <= {div_quo_q[ValW-2:0], 1'b1};
			end else begin
				div_rem_q <= div_shift[PrimeW-1:0];
				div_quo_q <= {div_quo_q[ValW-2:0], 1'b0};
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			d_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						cnt_q <= '0;
						d_q   <= TrialW'(2);
						if (in_bad) begin
							state_q <= ST_FIN;
						end else if (in_small) begin
							state_q <= ST_VAL;
						end else begin
							state_q <= ST_PRIME;
						end
					end
				end
				ST_PRIME: begin
					if (div_done_q) begin
						d_q <= d_nxt;
						if (rem_zero) begin
							state_q <= ST_FIN;
						end else if (d_past) begin
							state_q <= ST_VAL;
						end
					end
				end
				ST_VAL: begin
					if (div_done_q) begin
						if (rem_zero) begin
							cnt_q <= cnt_q + ExpW'(1);
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			v_q         <= in_v;
			p_q         <= in_p;
			res_valid_q <= 1'b0;
			res_exp_q   <= '0;
		end else if (state_q == ST_VAL && div_done_q && !rem_zero) begin
			res_valid_q <= (cnt_q != '0);
			res_exp_q   <= cnt_q;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FIN && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && out_free) begin
			out_flag_q <= res_valid_q;
			out_exp_q  <= res_exp_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_flag_q;
	assign m_tdata  = {(OutDataW - ExpW)'(0), out_exp_q};

	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !div_busy_q && !div_done_q)
		else $error("divider active while idle");

	a_done_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done_q |-> (state_q == ST_PRIME || state_q == ST_VAL))
		else $error("division result with no consumer");

	a_flag_exp: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("exponent nonzero on invalid result");

	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && out_free |=> m_tvalid && state_q == ST_IDLE)
		else $error("result not loaded");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ExpW'(30))
		else $error("exponent count out of range");

endmodule
